// ===== hw/rtl/lap_pkg.sv =====
package lap_pkg;

  localparam int PHASE_BITS = 24;
  localparam int SINE_BITS  = 10;
  localparam int MAX_STAGES = 8;
  localparam int STG_W      = $clog2(MAX_STAGES);
  localparam int STG_CNT_W  = 4;
  localparam int U_SHIFT    = 18 - SINE_BITS;

  localparam int SMP_W      = 16;
  localparam int ACC_W      = 24;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STAGES_IN_USE = 3'd4;

  typedef struct packed {
    logic [22:0]        phase_step;
    logic [15:0]        mod_depth;
    logic signed [15:0] feedback_gain;
    logic [15:0]        wet_mix;
    logic [3:0]         stages_in_use;
  } cfg_t;

  // multiplier operand pairs
  typedef logic [3:0] mul_op_t;
  localparam mul_op_t MUL_NONE = 4'd0;
  localparam mul_op_t MUL_UU   = 4'd1;
  localparam mul_op_t MUL_U2K  = 4'd2;
  localparam mul_op_t MUL_TU2  = 4'd3;
  localparam mul_op_t MUL_TU   = 4'd4;
  localparam mul_op_t MUL_FB   = 4'd5;
  localparam mul_op_t MUL_DL   = 4'd6;
  localparam mul_op_t MUL_TK   = 4'd7;
  localparam mul_op_t MUL_NAX  = 4'd8;
  localparam mul_op_t MUL_AY   = 4'd9;
  localparam mul_op_t MUL_DRY  = 4'd10;
  localparam mul_op_t MUL_XW   = 4'd11;

  // writeback operations, all but WB_NONE and WB_LW consume the product register
  typedef logic [3:0] wb_op_t;
  localparam wb_op_t WB_NONE = 4'd0;
  localparam wb_op_t WB_U2   = 4'd1;
  localparam wb_op_t WB_T1   = 4'd2;
  localparam wb_op_t WB_T2   = 4'd3;
  localparam wb_op_t WB_LFO  = 4'd4;
  localparam wb_op_t WB_X    = 4'd5;
  localparam wb_op_t WB_DL   = 4'd6;
  localparam wb_op_t WB_A    = 4'd7;
  localparam wb_op_t WB_Y    = 4'd8;
  localparam wb_op_t WB_S    = 4'd9;
  localparam wb_op_t WB_LW   = 4'd10;
  localparam wb_op_t WB_ACC  = 4'd11;
  localparam wb_op_t WB_OUT  = 4'd12;

  typedef struct packed {
    mul_op_t mul_op;
    wb_op_t  wb_op;
    logic    jump;
    logic    last;
  } ctrl_t;

  typedef struct packed {
    logic  en;
    ctrl_t cw;
  } seq_t;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LOOP_STEP = 5'd12;

  localparam logic [16:0] K_SIN_C = 17'd4926;
  localparam logic [16:0] K_T1    = 17'd42334;
  localparam logic [16:0] K_T2    = 17'd102944;
  localparam logic [16:0] K_DEPTH = 17'd52429;
  localparam logic [15:0] K_A_MIN = 16'd6554;
  localparam logic [16:0] UNIT    = 17'h10000;

  localparam logic signed [15:0] FB_LIMIT = 16'sd31130;

  function automatic ctrl_t mk(input mul_op_t m, input wb_op_t w, input logic j,
                               input logic l);
    ctrl_t c;
    c.mul_op = m;
    c.wb_op  = w;
    c.jump   = j;
    c.last   = l;
    return c;
  endfunction

  // microprogram: sine polynomial, feedback, coefficient, section loop, mix
  function automatic ctrl_t lap_ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    unique case (step)
      5'd0:    c = mk(MUL_UU,   WB_NONE, 1'b0, 1'b0);
      5'd1:    c = mk(MUL_NONE, WB_U2,   1'b0, 1'b0);
      5'd2:    c = mk(MUL_U2K,  WB_NONE, 1'b0, 1'b0);
      5'd3:    c = mk(MUL_NONE, WB_T1,   1'b0, 1'b0);
      5'd4:    c = mk(MUL_TU2,  WB_NONE, 1'b0, 1'b0);
      5'd5:    c = mk(MUL_NONE, WB_T2,   1'b0, 1'b0);
      5'd6:    c = mk(MUL_TU,   WB_NONE, 1'b0, 1'b0);
      5'd7:    c = mk(MUL_FB,   WB_LFO,  1'b0, 1'b0);
      5'd8:    c = mk(MUL_DL,   WB_X,    1'b0, 1'b0);
      5'd9:    c = mk(MUL_NONE, WB_DL,   1'b0, 1'b0);
      5'd10:   c = mk(MUL_TK,   WB_NONE, 1'b0, 1'b0);
      5'd11:   c = mk(MUL_NONE, WB_A,    1'b0, 1'b0);
      5'd12:   c = mk(MUL_NAX,  WB_NONE, 1'b0, 1'b0);
      5'd13:   c = mk(MUL_NONE, WB_Y,    1'b0, 1'b0);
      5'd14:   c = mk(MUL_AY,   WB_NONE, 1'b0, 1'b0);
      5'd15:   c = mk(MUL_NONE, WB_S,    1'b1, 1'b0);
      5'd16:   c = mk(MUL_DRY,  WB_LW,   1'b0, 1'b0);
      5'd17:   c = mk(MUL_XW,   WB_ACC,  1'b0, 1'b0);
      5'd18:   c = mk(MUL_NONE, WB_OUT,  1'b0, 1'b1);
      default: c = mk(MUL_NONE, WB_NONE, 1'b0, 1'b0);
    endcase
    return c;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    if (v > 32'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lap_if.sv =====
interface lap_in_if;
  import lap_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [SMP_W-1:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface lap_out_if;
  import lap_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [SMP_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== hw/rtl/lap_cfg_regs.sv =====
module lap_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lap_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [lap_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output lap_pkg::cfg_t                    cfg
);
  import lap_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step    <= 23'd133;
      cfg_r.mod_depth     <= 16'd45875;
      cfg_r.feedback_gain <= 16'sd6554;
      cfg_r.wet_mix       <= 16'd32768;
      cfg_r.stages_in_use <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PHASE_STEP:    cfg_r.phase_step    <= cfg_wdata;
        REG_MOD_DEPTH:     cfg_r.mod_depth     <= cfg_wdata[15:0];
        REG_FEEDBACK_GAIN: cfg_r.feedback_gain <= $signed(cfg_wdata[15:0]);
        REG_WET_MIX:       cfg_r.wet_mix       <= cfg_wdata[15:0];
        REG_STAGES_IN_USE: cfg_r.stages_in_use <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/lap_seq.sv =====
module lap_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          more,
  input  logic          out_free,
  output logic          busy,
  output lap_pkg::seq_t seq
);
  import lap_pkg::*;

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  ctrl_t             cw;
  logic              en;

  assign cw = lap_ucode(step_r);
  // the last step holds until the output register can take the sample
  assign en = busy_r && !(cw.last && !out_free);

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (en) begin
      priority if (cw.last) begin
        busy_nxt = 1'b0;
      end else if (cw.jump && more) begin
        step_nxt = LOOP_STEP;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  assign busy   = busy_r;
  assign seq.en = en;
  assign seq.cw = cw;

endmodule

// ===== hw/rtl/lap_dp.sv =====
module lap_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [lap_pkg::SMP_W-1:0] sample_in,
  input  lap_pkg::cfg_t                    cfg,
  input  lap_pkg::seq_t                    seq,
  input  logic                             out_ready,
  output logic                             more,
  output logic                             out_valid,
  output logic signed [lap_pkg::SMP_W-1:0] sample_out
);
  import lap_pkg::*;

  // state cleared at reset
  logic [PHASE_BITS-1:0]     ph_r;
  logic signed [SMP_W-1:0]   lw_r;
  logic signed [ACC_W-1:0]   mem_r [MAX_STAGES];
  logic                      out_valid_r;

  // working registers
  logic signed [SMP_W-1:0]   dry_r;
  logic [16:0]               u_r, u2_r, t_r;
  logic                      q_hi_r;
  logic [15:0]               a_r;
  logic signed [ACC_W-1:0]   x_r, y_r;
  logic [STG_W-1:0]          st_r;
  logic signed [PROD_W-1:0]  p_r, acc_r;
  logic signed [SMP_W-1:0]   out_r;

  logic [SINE_BITS-1:0]      idx;
  logic [SINE_BITS-3:0]      pos;
  logic [16:0]               u_raw, u_start;
  logic [STG_CNT_W-1:0]      stg_eff;
  logic [22:0]               step_eff;
  logic signed [15:0]        fbc;
  logic [16:0]               dry_share;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_B_W-1:0] neg_a;
  logic [17:0]               s18;
  logic [16:0]               s_c;
  logic [17:0]               l_sum;
  logic [15:0]               lfo;
  logic signed [23:0]        x_nxt, s_nxt;
  logic signed [PROD_W:0]    mix_sum;
  logic                      fin;

  // quarter-wave position from the phase
  assign idx     = ph_r[PHASE_BITS-1 -: SINE_BITS];
  assign pos     = idx[SINE_BITS-3:0];
  assign u_raw   = 17'(pos) << U_SHIFT;
  assign u_start = idx[SINE_BITS-2] ? 17'(UNIT - u_raw) : u_raw;

  always_comb begin
    if (cfg.stages_in_use == '0) begin
      stg_eff = STG_CNT_W'(1);
    end else if (cfg.stages_in_use > STG_CNT_W'(MAX_STAGES)) begin
      stg_eff = STG_CNT_W'(MAX_STAGES);
    end else begin
      stg_eff = cfg.stages_in_use;
    end
  end

  assign more     = (STG_CNT_W'(st_r) + STG_CNT_W'(1)) < stg_eff;
  assign step_eff = (cfg.phase_step == '0) ? 23'd1 : cfg.phase_step;

  always_comb begin
    if (cfg.feedback_gain > FB_LIMIT) begin
      fbc = FB_LIMIT;
    end else if (cfg.feedback_gain < -FB_LIMIT) begin
      fbc = -FB_LIMIT;
    end else begin
      fbc = cfg.feedback_gain;
    end
  end

  assign dry_share = 17'(UNIT - {1'b0, cfg.wet_mix});
  assign neg_a     = 18'sd0 - $signed({2'b00, a_r});

  always_comb begin
    unique case (seq.cw.mul_op)
      MUL_UU:  begin mul_a = $signed({8'b0, u_r});  mul_b = $signed({1'b0, u_r});   end
      MUL_U2K: begin mul_a = $signed({8'b0, u2_r}); mul_b = $signed({1'b0, K_SIN_C}); end
      MUL_TU2: begin mul_a = $signed({8'b0, t_r});  mul_b = $signed({1'b0, u2_r});  end
      MUL_TU:  begin mul_a = $signed({8'b0, t_r});  mul_b = $signed({1'b0, u_r});   end
      MUL_FB:  begin mul_a = MUL_A_W'(lw_r);        mul_b = MUL_B_W'(fbc);          end
      MUL_DL:  begin
        mul_a = $signed({9'b0, cfg.mod_depth});
        mul_b = $signed({1'b0, t_r});
      end
      MUL_TK:  begin mul_a = $signed({8'b0, t_r});  mul_b = $signed({1'b0, K_DEPTH}); end
      MUL_NAX: begin mul_a = MUL_A_W'(x_r);         mul_b = neg_a;                  end
      MUL_AY:  begin mul_a = MUL_A_W'(y_r);         mul_b = $signed({2'b00, a_r});  end
      MUL_DRY: begin mul_a = MUL_A_W'(dry_r);       mul_b = $signed({1'b0, dry_share}); end
      MUL_XW:  begin mul_a = MUL_A_W'(x_r);         mul_b = $signed({2'b00, cfg.wet_mix}); end
      default: begin mul_a = '0;                    mul_b = '0;                     end
    endcase
  end

  // lfo = (1 +/- sine) / 2, sine capped at one
  assign s18   = p_r[33:16];
  assign s_c   = (s18 > 18'd65536) ? UNIT : s18[16:0];
  assign l_sum = q_hi_r ? ({1'b0, UNIT} - {1'b0, s_c}) : ({1'b0, UNIT} + {1'b0, s_c});
  assign lfo   = (l_sum[17:1] > 17'd65535) ? 16'hFFFF : l_sum[16:1];

  assign x_nxt   = sat24(32'(dry_r) + 32'($signed(p_r[PROD_W-1:15])));
  assign s_nxt   = sat24(32'(x_r) + 32'($signed(p_r[PROD_W-1:16])));
  assign mix_sum = (PROD_W+1)'(acc_r) + (PROD_W+1)'(p_r);

  assign fin = seq.en && (seq.cw.wb_op == WB_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= '0;
      lw_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        mem_r[i] <= '0;
      end
    end else begin
      if (fin) begin
        out_valid_r <= 1'b1;
        ph_r        <= ph_r + PHASE_BITS'(step_eff);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (seq.en && seq.cw.wb_op == WB_S) begin
        mem_r[st_r] <= s_nxt;
      end
      if (seq.en && seq.cw.wb_op == WB_LW) begin
        lw_r <= sat16(32'(x_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dry_r  <= sample_in;
      u_r    <= u_start;
      q_hi_r <= idx[SINE_BITS-1];
    end
    if (seq.en) begin
      if (seq.cw.mul_op != MUL_NONE) begin
        p_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      unique case (seq.cw.wb_op)
        WB_U2:  u2_r <= p_r[32:16];
        WB_T1:  t_r  <= K_T1 - p_r[32:16];
        WB_T2:  t_r  <= K_T2 - p_r[32:16];
        WB_LFO: t_r  <= {1'b0, lfo};
        WB_X:   x_r  <= x_nxt;
        WB_DL:  t_r  <= {1'b0, p_r[31:16]};
        WB_A: begin
          a_r  <= K_A_MIN + p_r[31:16];
          st_r <= '0;
        end
        WB_Y:   y_r  <= sat24(32'($signed(p_r[PROD_W-1:16])) + 32'(mem_r[st_r]));
        WB_S: begin
          x_r  <= y_r;
          st_r <= st_r + 1'b1;
        end
        WB_ACC: acc_r <= p_r;
        WB_OUT: out_r <= sat16(32'($signed(mix_sum[PROD_W:16])));
        default: ;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign sample_out = out_r;

endmodule

// ===== hw/rtl/lfo_allpass_phaser.sv =====
// Channel  Dir  Payload                     Transfer
// in_ch    in   sample_in  (s16, Q1.15)     valid && ready
// out_ch   out  sample_out (s16, Q1.15)     valid && ready
// cfg      in   cfg_idx, cfg_wdata (23b)    cfg_we
//
// Each item runs the microprogram after its transfer, with N = sections in use (1..8):
// one step per cycle, unless the final step stalls, around a single 25x18 multiplier,
// four steps per allpass section, looped N times. A new input is taken the cycle after the
// program ends. The output register lets the next item start while a result
// waits; the final step stalls only if that register is still full.
// Reset (rst_n low, synchronous) restores the registers and clears phase,
// feedback and section memories.
module lfo_allpass_phaser (
  input  logic                            clk,
  input  logic                            rst_n,
  lap_in_if.sink                          in_ch,
  lap_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [lap_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lap_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lap_pkg::*;

  cfg_t cfg;
  seq_t seq;
  logic busy;
  logic start;
  logic more;
  logic out_valid;
  logic out_free;

  assign start    = in_ch.valid && !busy;
  assign out_free = !out_valid || out_ch.ready;

  lap_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lap_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .more     (more),
    .out_free (out_free),
    .busy     (busy),
    .seq      (seq)
  );

  lap_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .sample_in  (in_ch.sample_in),
    .cfg        (cfg),
    .seq        (seq),
    .out_ready  (out_ch.ready),
    .more       (more),
    .out_valid  (out_valid),
    .sample_out (out_ch.sample_out)
  );

  assign in_ch.ready  = !busy;
  assign out_ch.valid = out_valid;

endmodule

// ===== hw/rtl/lap_checker.sv =====
module lap_props (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] out_data
);

  // samples accepted but not yet delivered
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in work");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3 && (!out_valid || pend_r != 2'd0))
    else $error("output count does not match input count");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd2 |-> !in_ready)
    else $error("input ready with work and output both full");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

endmodule

bind lfo_allpass_phaser lap_props u_lap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.sample_out)
);
